// ----- hw/rtl/blst_pkg.sv -----
`default_nettype none

package blst_pkg;

    localparam logic [3:0] OP_INS_FRONT = 4'd0;
    localparam logic [3:0] OP_INS_BACK  = 4'd1;
    localparam logic [3:0] OP_INS_AT    = 4'd2;
    localparam logic [3:0] OP_REM_FRONT = 4'd3;
    localparam logic [3:0] OP_REM_BACK  = 4'd4;
    localparam logic [3:0] OP_REM_AT    = 4'd5;
    localparam logic [3:0] OP_MODIFY    = 4'd6;
    localparam logic [3:0] OP_SEARCH    = 4'd7;
    localparam logic [3:0] OP_READ_AT   = 4'd8;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] value_in;
        logic [2:0]         position;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic [2:0]         found_index;
        logic [2:0]         status;
        logic [3:0]         item_count;
    } out_word_t;

    typedef struct packed {
        logic exec;
        logic scan_begin;
        logic scan_next;
        logic scan_load;
    } blst_cmd_t;

    typedef struct packed {
        logic is_scan;
        logic scan_done;
    } blst_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/blst_dp.sv -----
`default_nettype none

module blst_dp import blst_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire in_word_t  s_word,
    input  wire blst_cmd_t cmd,
    output blst_sts_t      sts,
    output out_word_t      m_word
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 3) ? CW : 3;

    logic signed [31:0] entries_reg [DEPTH];
    logic signed [31:0] entries_next [DEPTH];
    logic signed [31:0] prev_w [DEPTH];
    logic signed [31:0] nxt_w [DEPTH];
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic signed [31:0] key_reg;
    logic [AW-1:0]      idx_reg;
    out_word_t          out_reg;

    logic [XW-1:0]      cnt_x;
    logic [XW-1:0]      pos_x;
    logic [XW-1:0]      at_x;
    logic [XW-1:0]      idx_x;
    logic [AW-1:0]      at_idx;
    logic               full;
    logic               empty;
    logic               do_ins;
    logic               do_rem;
    logic               do_mod;
    logic               do_read;
    logic               is_scan;
    logic [2:0]         st;
    logic signed [31:0] rd_word;
    logic signed [31:0] scan_word;
    logic               scan_hit;
    logic               scan_last;
    out_word_t          exec_word;
    out_word_t          scan_out;

    assign cnt_x  = XW'(count_reg);
    assign pos_x  = XW'(s_word.position);
    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign at_idx = at_x[AW-1:0];

    always_comb begin
        do_ins  = 1'b0;
        do_rem  = 1'b0;
        do_mod  = 1'b0;
        do_read = 1'b0;
        is_scan = 1'b0;
        at_x    = '0;
        st      = ST_OK;
        unique case (s_word.op)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                if (s_word.op == OP_INS_BACK) begin
                    at_x = cnt_x;
                end else if (s_word.op == OP_INS_AT) begin
                    at_x = pos_x;
                end
                if (full) begin
                    st = ST_FULL;
                end else if (at_x > cnt_x) begin
                    st = ST_RANGE;
                end else begin
                    do_ins = 1'b1;
                end
            end
            OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
                if (s_word.op == OP_REM_BACK) begin
                    at_x = cnt_x - XW'(1);
                end else if (s_word.op == OP_REM_AT) begin
                    at_x = pos_x;
                end
                if (empty) begin
                    st = ST_EMPTY;
                end else if (at_x >= cnt_x) begin
                    st = ST_RANGE;
                end else begin
                    do_rem = 1'b1;
                end
            end
            OP_MODIFY, OP_READ_AT: begin
                at_x = pos_x;
                if (empty) begin
                    st = ST_EMPTY;
                end else if (at_x >= cnt_x) begin
                    st = ST_RANGE;
                end else if (s_word.op == OP_MODIFY) begin
                    do_mod = 1'b1;
                end else begin
                    do_read = 1'b1;
                end
            end
            OP_SEARCH: begin
                if (empty) begin
                    st = ST_EMPTY;
                end else begin
                    is_scan = 1'b1;
                end
            end
            default: begin
                st = ST_RANGE;
            end
        endcase
    end

    assign rd_word = entries_reg[at_idx];

    always_comb begin
        count_next = count_reg;
        if (do_ins) begin
            count_next = count_reg + CW'(1);
        end else if (do_rem) begin
            count_next = count_reg - CW'(1);
        end
    end

    // per-cell shift network
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam logic [XW-1:0] GI = XW'(g);
        if (g > 0) begin : g_prev
            assign prev_w[g] = entries_reg[g-1];
        end else begin : g_prev0
            assign prev_w[g] = '0;
        end
        if (g < DEPTH - 1) begin : g_nxt
            assign nxt_w[g] = entries_reg[g+1];
        end else begin : g_nxt_last
            assign nxt_w[g] = '0;
        end
        always_comb begin
            entries_next[g] = entries_reg[g];
            if (do_ins) begin
                if (GI == at_x) begin
                    entries_next[g] = s_word.value_in;
                end else if (GI > at_x && GI <= cnt_x) begin
                    entries_next[g] = prev_w[g];
                end
            end else if (do_rem) begin
                if (GI >= at_x && (GI + XW'(1)) < cnt_x) begin
                    entries_next[g] = nxt_w[g];
                end
            end else if (do_mod && GI == at_x) begin
                entries_next[g] = s_word.value_in;
            end
        end
    end

    always_comb begin
        exec_word.value_out   = (do_rem || do_read) ? rd_word : '0;
        exec_word.found_index = '0;
        exec_word.status      = st;
        exec_word.item_count  = 4'(count_next);
    end

    // sequential search, one entry per cycle
    assign idx_x     = XW'(idx_reg);
    assign scan_word = entries_reg[idx_reg];
    assign scan_hit  = (scan_word == key_reg);
    assign scan_last = ((idx_x + XW'(1)) == cnt_x);

    always_comb begin
        scan_out.value_out   = scan_hit ? scan_word : '0;
        scan_out.found_index = scan_hit ? idx_x[2:0] : 3'd0;
        scan_out.status      = scan_hit ? ST_OK : ST_NOTFOUND;
        scan_out.item_count  = 4'(count_reg);
    end

    assign sts.is_scan   = is_scan;
    assign sts.scan_done = scan_hit || scan_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.exec) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            entries_reg <= entries_next;
        end
        if (cmd.scan_begin) begin
            key_reg <= s_word.value_in;
            idx_reg <= '0;
        end else if (cmd.scan_next) begin
            idx_reg <= idx_reg + AW'(1);
        end
        if (cmd.exec) begin
            out_reg <= exec_word;
        end else if (cmd.scan_load) begin
            out_reg <= scan_out;
        end
    end

    assign m_word = out_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("list count beyond depth");

    a_ins_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && do_ins) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the list");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/blst_ctrl.sv -----
`default_nettype none

module blst_ctrl import blst_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    input  wire blst_sts_t sts,
    output blst_cmd_t      cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    if (sts.is_scan) begin
                        cmd.scan_begin = 1'b1;
                        state_next     = S_SCAN;
                    end else begin
                        cmd.exec     = 1'b1;
                        m_valid_next = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (sts.scan_done) begin
                    if (out_free) begin
                        cmd.scan_load = 1'b1;
                        m_valid_next  = 1'b1;
                        state_next    = S_IDLE;
                    end
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec || cmd.scan_load) |-> (!m_valid_reg || m_ready))
        else $error("result word overwritten before taken");

    a_scan_end: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_load |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("search result not presented");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/bounded_array_list.sv -----
// the result word is registered, valid the cycle after accept, for all but search
// non-empty search: key registered, entries compared from 0 until a hit or the last one
// throughput: one request per cycle if m_ready is high; search steps one entry a cycle
// reset: count and handshake state cleared, list empty; stored entries are not cleared
`default_nettype none

module bounded_array_list import blst_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_word_t s_word,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_word_t     m_word
);

    blst_cmd_t cmd;
    blst_sts_t sts;

    blst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    blst_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_word  (s_word),
        .cmd     (cmd),
        .sts     (sts),
        .m_word  (m_word)
    );

endmodule

`default_nettype wire
